@@ hw/rtl/u2a_pkg.sv @@
// Shared types, constants and helpers for the number-to-ASCII renderer.
package u2a_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int FIELD_WIDTH     = 64;
  localparam int CHAR_WIDTH      = 7;
  localparam int DIGIT_WIDTH     = 4;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_WIDTH-1:0] CHAR_X    = 7'h78;  // 'x'

  localparam logic KIND_DEC = 1'b0;
  localparam logic KIND_HEX = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [FIELD_WIDTH-1:0] value;
  } item_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] character;
    logic                  last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_DEC_EMIT,
    ST_PRE_ZERO,
    ST_PRE_X,
    ST_HEX_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  // Lowercase hex digit to ASCII.
  function automatic logic [CHAR_WIDTH-1:0] hex_char(input logic [DIGIT_WIDTH-1:0] nib);
    logic [CHAR_WIDTH-1:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {3'd0, nib};
    end else begin
      c = 7'h57 + {3'd0, nib};  // 'a' - 10
    end
    return c;
  endfunction

  // Decimal digit to ASCII.
  function automatic logic [CHAR_WIDTH-1:0] dec_char(input logic [DIGIT_WIDTH-1:0] d);
    return CHAR_ZERO + {3'd0, d};
  endfunction

endpackage

@@ hw/rtl/u2a_cell.sv @@
// One BCD digit cell of the double-dabble chain, also used as a digit shifter.
module u2a_cell
  import u2a_pkg::*;
(
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic [DIGIT_WIDTH-1:0] load_digit,
  input  logic                   bit_in,
  input  logic [DIGIT_WIDTH-1:0] digit_in,
  output logic                   bit_out,
  output logic [DIGIT_WIDTH-1:0] digit
);

  logic [DIGIT_WIDTH-1:0] adj;

  // add 3 when the digit would overflow past 9 after doubling
  assign adj     = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign bit_out = adj[DIGIT_WIDTH-1];

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD:   digit <= digit;
      CELL_LOAD:   digit <= load_digit;
      CELL_DABBLE: digit <= {adj[DIGIT_WIDTH-2:0], bit_in};
      CELL_SHIFT:  digit <= digit_in;
    endcase
  end

endmodule

@@ hw/rtl/u64_to_ascii_digits_core.sv @@
// Top level: renders an unsigned number as decimal or 0x-prefixed hex ASCII text.
//
// Usage:
//   Drive item (kind, value) and raise start; the beat is taken at the rising
//   edge where start is high and busy is low. busy stays high until the run's
//   final character has been produced.
//   Characters leave on result (character, last), one beat per cycle marked by
//   result_valid, most significant character first; last flags the end of the
//   run. The receiver cannot stall: every result beat is taken in its cycle.
// Operation:
//   Decimal: serial double dabble through a chain of DEC_DIGITS BCD cells,
//   then the digits are shifted out of the top cell (leading zeros are
//   dropped, so some of these shift steps show nothing).
//   Hex: the nibbles are loaded straight into the cells; the two prefix
//   characters are followed by HEX_DIGITS digits shifted out of the top cell.
//   Each character is registered and appears on result in the cycle after
//   it is picked.
// Reset:
//   rst (synchronous, active high) returns the sequencer to idle and drops
//   any pending result strobe; digit storage is not cleared.
module u64_to_ascii_digits_core
  import u2a_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    result_valid,
  output result_t result
);

  // decimal digits needed: floor(W*log10(2)) + 1
  localparam int DEC_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int HEX_W      = HEX_DIGITS * 4;
  localparam int HEX_OFFSET = DEC_DIGITS - HEX_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_WIDTH);

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_WIDTH - 1);
  localparam logic [CNT_W-1:0] DEC_LAST  = CNT_W'(DEC_DIGITS - 1);
  localparam logic [CNT_W-1:0] HEX_LAST  = CNT_W'(HEX_DIGITS - 1);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  state_t state, state_next;

  logic [CNT_W-1:0]       cnt;
  logic                   started;
  logic [VALUE_WIDTH-1:0] shreg;
  logic [HEX_W-1:0]       value_pad;

  cell_ctrl_t             cell_ctrl;
  logic                   emit;
  logic [CHAR_WIDTH-1:0]  emit_char;
  logic                   emit_last;

  logic                   bit_chain [0:DEC_DIGITS];
  logic [DIGIT_WIDTH-1:0] digits    [0:DEC_DIGITS-1];
  logic [DIGIT_WIDTH-1:0] top_digit;

  assign value_pad = HEX_W'(item.value[VALUE_WIDTH-1:0]);
  assign top_digit = digits[DEC_DIGITS-1];
  assign busy      = (state != ST_IDLE);

  // Cell chain: bits ripple upward during conversion, digits move upward
  // one cell per cycle during emission.
  assign bit_chain[0] = shreg[VALUE_WIDTH-1];

  for (genvar i = 0; i < DEC_DIGITS; i++) begin : g_cell
    logic [DIGIT_WIDTH-1:0] load_d;
    logic [DIGIT_WIDTH-1:0] below_d;

    if (i >= HEX_OFFSET) begin : g_hex
      // top-aligned so the most significant nibble sits in the top cell
      assign load_d = (item.kind == KIND_HEX) ?
                      value_pad[DIGIT_WIDTH*(i-HEX_OFFSET) +: DIGIT_WIDTH] : 4'd0;
    end else begin : g_nohex
      assign load_d = 4'd0;
    end

    if (i == 0) begin : g_bottom
      assign below_d = 4'd0;
    end else begin : g_mid
      assign below_d = digits[i-1];
    end

    u2a_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .load_digit (load_d),
      .bit_in     (bit_chain[i]),
      .digit_in   (below_d),
      .bit_out    (bit_chain[i+1]),
      .digit      (digits[i])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (item.kind == KIND_HEX) ? ST_PRE_ZERO : ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt == CONV_LAST) state_next = ST_DEC_EMIT;
      end
      ST_DEC_EMIT: begin
        if (cnt == DEC_LAST) state_next = ST_IDLE;
      end
      ST_PRE_ZERO: state_next = ST_PRE_X;
      ST_PRE_X:    state_next = ST_HEX_EMIT;
      ST_HEX_EMIT: begin
        if (cnt == HEX_LAST) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell command and the character picked this cycle.
  always_comb begin
    cell_ctrl.op = CELL_HOLD;
    emit         = 1'b0;
    emit_char    = CHAR_ZERO;
    emit_last    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) cell_ctrl.op = CELL_LOAD;
      end
      ST_CONV: cell_ctrl.op = CELL_DABBLE;
      ST_DEC_EMIT: begin
        cell_ctrl.op = CELL_SHIFT;
        emit_char    = dec_char(top_digit);
        emit_last    = (cnt == DEC_LAST);
        // drop leading zeros, but always show the units digit
        emit         = (top_digit != 4'd0) || started || emit_last;
      end
      ST_PRE_ZERO: begin
        emit      = 1'b1;
        emit_char = CHAR_ZERO;
      end
      ST_PRE_X: begin
        emit      = 1'b1;
        emit_char = CHAR_X;
      end
      ST_HEX_EMIT: begin
        cell_ctrl.op = CELL_SHIFT;
        emit         = 1'b1;
        emit_char    = hex_char(top_digit);
        emit_last    = (cnt == HEX_LAST);
      end
      default: cell_ctrl.op = CELL_HOLD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      started      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      // restart the step count on every phase change
      cnt          <= (state_next != state) ? '0 : cnt + CNT_ONE;
      if (state == ST_IDLE) begin
        started <= 1'b0;
      end else if (emit) begin
        started <= 1'b1;
      end
      result_valid <= emit;
    end
  end

  // Payload: value shifter and result beat.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      shreg <= item.value[VALUE_WIDTH-1:0];
    end else if (state == ST_CONV) begin
      shreg <= shreg << 1;
    end
    result.character <= emit_char;
    result.last      <= emit_last;
  end

endmodule

@@ hw/rtl/u2a_checker.sv @@
// Port-level checker for the number-to-ASCII renderer, bound to the top level.
module u2a_checker
  import u2a_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input item_t   item,
  input logic    busy,
  input logic    result_valid,
  input result_t result
);

  // an accepted beat occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // a run never ends early: while characters are still due, the block is busy
  a_mid_run_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("non-final character while idle");

  // a run's final character is not followed at once by another
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("character right after end of run");

  // hex runs open with the '0' of the prefix
  a_hex_prefix: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.kind == KIND_HEX)) |=> ##1
      (result_valid && (result.character == CHAR_ZERO) && !result.last))
    else $error("hex run does not open with prefix");

endmodule

bind u64_to_ascii_digits_core u2a_checker u_u2a_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .item         (item),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

@@ tb/u64_to_ascii_digits_core_test.sv @@
// Self-checking testbench for u64_to_ascii_digits_core: decimal and hex text runs.
module u64_to_ascii_digits_core_test
  import u2a_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW         = VALUE_WIDTH_DEF;
  localparam int HEX_COUNT  = (VW + 3) / 4;
  localparam int ITEM_COUNT = 320;

  // Expected text for every accepted beat, one character per entry, oldest first.
  class char_run_book;
    result_t pending_chars[$];
    int      mismatches = 0;
    string   digit_set  = "0123456789abcdef";

    function void add_char(byte ch, bit fin);
      result_t r;
      r.character = ch[CHAR_WIDTH-1:0];
      r.last      = fin;
      pending_chars.push_back(r);
    endfunction

    // Render one input beat into the characters the block must emit.
    function void note_value(item_t it);
      logic [FIELD_WIDTH-1:0] v;
      byte                    digits[$];
      v = it.value;
      if (VW < FIELD_WIDTH) v = v & ((64'd1 << VW) - 64'd1);
      if (it.kind == KIND_HEX) begin
        add_char("0", 1'b0);
        add_char("x", 1'b0);
        for (int d = HEX_COUNT - 1; d >= 0; d--) begin
          add_char(digit_set[(v >> (d * 4)) & 64'hf], d == 0);
        end
      end else if (v == 0) begin
        add_char("0", 1'b1);
      end else begin
        // Peel off decimal digits least significant first, then emit reversed.
        while (v != 0) begin
          digits.push_front(digit_set[v % 64'd10]);
          v = v / 64'd10;
        end
        foreach (digits[i]) add_char(digits[i], i == digits.size() - 1);
      end
    endfunction

    function void check_char(result_t got);
      result_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %h last %b",
                 $time, got.character, got.last);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.character !== want.character) begin
        $display("%0t: character mismatch: expected %h, actual %h",
                 $time, want.character, got.character);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    result_valid;
  result_t result;

  char_run_book runs = new();
  bit           quiet_span = 1'b0;

  u64_to_ascii_digits_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  always #1 clk = ~clk;

  // The receiver cannot stall: take every strobed character at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && result_valid) runs.check_char(result);
  end

  // Present one beat, optionally after an idle gap, and hold it until taken.
  // Start stays high from one beat to the next when no gap is drawn, so the
  // block sees start already waiting at the moment busy falls.
  task automatic send_value(input logic kind, input logic [FIELD_WIDTH-1:0] value);
    int gap;
    gap = 0;
    if (!quiet_span && $urandom_range(99) < 16) gap = $urandom_range(1, 90);
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    item.kind  <= kind;
    item.value <= value;
    // Busy is sampled before the edge updates it, so this is the acceptance edge.
    do @(posedge clk); while (busy);
    runs.note_value(item);
  endtask

  // Drop start, then hold off new beats until every expected character has come back.
  task automatic drain_runs();
    @(negedge clk);
    start <= 1'b0;
    while (runs.pending() != 0) @(posedge clk);
  endtask

  // Draw a value whose decimal length spreads over the whole 1..20 range.
  function automatic logic [FIELD_WIDTH-1:0] pick_value();
    logic [FIELD_WIDTH-1:0] v;
    logic [FIELD_WIDTH-1:0] p;
    int                     sel;
    sel = $urandom_range(99);
    v   = {$urandom, $urandom};
    if (sel < 40) begin
      return v;
    end else if (sel < 80) begin
      return v >> $urandom_range(63);
    end else if (sel < 90) begin
      // Hit the digit-count boundaries: a power of ten or one below it.
      p = 64'd1;
      repeat ($urandom_range(0, 19)) p = p * 64'd10;
      return p - 64'($urandom_range(0, 1));
    end
    return 64'($urandom_range(0, 20));
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: decimal extremes and length boundaries.
    send_value(KIND_DEC, 64'd0);
    send_value(KIND_DEC, 64'd1);
    send_value(KIND_DEC, 64'd9);
    send_value(KIND_DEC, 64'd10);
    send_value(KIND_DEC, 64'd99);
    send_value(KIND_DEC, 64'd100);
    send_value(KIND_DEC, 64'd9999999999999999999);
    send_value(KIND_DEC, 64'd10000000000000000000);
    send_value(KIND_DEC, 64'h8000_0000_0000_0000);
    send_value(KIND_DEC, 64'hffff_ffff_ffff_ffff);
    send_value(KIND_DEC, 64'h5555_5555_5555_5555);
    // Directed: hex runs, leading zeros kept, every nibble value.
    send_value(KIND_HEX, 64'h0);
    send_value(KIND_HEX, 64'h1);
    send_value(KIND_HEX, 64'hffff_ffff_ffff_ffff);
    send_value(KIND_HEX, 64'h0123_4567_89ab_cdef);
    send_value(KIND_HEX, 64'hfedc_ba98_7654_3210);
    send_value(KIND_HEX, 64'h8000_0000_0000_0000);
    send_value(KIND_HEX, 64'haaaa_aaaa_aaaa_aaaa);
    drain_runs();

    // Random: mixed kinds, with a long stretch of back-to-back beats mid-run.
    for (int n = 0; n < ITEM_COUNT - 18; n++) begin
      quiet_span = (n >= 100) && (n < 180);
      if (n == 200) drain_runs();
      send_value(1'($urandom_range(0, 1)), pick_value());
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain, then watch for stray characters for longer than one decimal run.
    drain_runs();
    repeat (VW + 40) @(posedge clk);
    if (runs.mismatches == 0 && runs.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
